FILE: hw/rtl/vkd_pkg.sv
// Shared types, constants and helper functions of the kick/drift particle integrator.
package vkd_pkg;

   localparam int FRAC_BITS = 16;
   localparam int WORD_W    = 32;
   localparam int MASS_W    = 31;
   localparam int WGT_W     = 17;
   localparam int STEP_W    = 31;
   localparam int MODE_W    = 2;

   localparam int PROD_W  = WORD_W + STEP_W;
   localparam int NUM_W   = PROD_W + FRAC_BITS;
   localparam int DEN_W   = MASS_W + WGT_W;
   localparam int QUO_W   = 35;
   localparam int REM_W   = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;
   localparam int SUM_W   = ((PROD_W - FRAC_BITS > WORD_W) ? PROD_W - FRAC_BITS : WORD_W) + 2;
   localparam int LANE_LAT = QUO_W + 5;

   localparam logic [QUO_W-1:0] HUGE_STEP = QUO_W'(1) << (QUO_W - 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_MODE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHTING_ON = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GROUP_BIT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FORCE_SCALE  = 3'd4;

   localparam logic [MODE_W-1:0] MODE_KICK  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DRIFT = 2'd1;

   typedef struct packed {
      logic [31:0]        group_mask;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic signed [31:0] force_z;
      logic [MASS_W-1:0]  particle_mass;
      logic [WGT_W-1:0]   particle_weight;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_pos_x;
      logic signed [31:0] new_pos_y;
      logic signed [31:0] new_pos_z;
      logic signed [31:0] new_vel_x;
      logic signed [31:0] new_vel_y;
      logic signed [31:0] new_vel_z;
      logic               was_selected;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic sel;
      logic do_kick;
      logic do_drift;
      logic weight;
   } ctrl_type;

   typedef struct packed {
      req_type  item;
      ctrl_type ctrl;
   } entry_type;

   typedef struct packed {
      logic [STEP_W-1:0] time_step;
      logic [STEP_W-1:0] force_scale;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] pos;
      logic signed [31:0] vel;
      logic signed [31:0] frc;
      ctrl_type           ctrl;
   } lane_in_type;

   typedef struct packed {
      logic signed [31:0] pos;
      logic signed [31:0] vel;
      logic               neg;
      logic               kick_ok;
      logic               clamp;
      logic               drift;
      logic               sel;
   } lane_side_type;

   typedef struct packed {
      logic signed [31:0] word;
      logic               sat;
   } clip_type;

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      mag32 = v[31] ? (~v + 32'd1) : v;
   endfunction

   function automatic clip_type clip_word(input logic signed [SUM_W-1:0] v);
      clip_type r;
      logic [SUM_W-WORD_W:0] hi;
      hi = v[SUM_W-1:WORD_W-1];
      if (hi == '0 || hi == '1) begin
         r.word = v[WORD_W-1:0];
         r.sat  = 1'b0;
      end else begin
         r.word = v[SUM_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
         r.sat  = 1'b1;
      end
      clip_word = r;
   endfunction

endpackage

FILE: hw/rtl/vkd_front.sv
// Front end: configuration registers, request acceptance and group classification.
module vkd_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  vkd_pkg::req_type          req_data,
   input  logic                      csr_we,
   input  logic [vkd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]               csr_wdata,
   input  logic                      q_full,
   output logic                      push,
   output vkd_pkg::entry_type        push_data,
   output vkd_pkg::cfg_type          cfg
);
   import vkd_pkg::*;

   logic [MODE_W-1:0] step_mode_ff, step_mode_in;
   logic              weighting_ff, weighting_in;
   logic [31:0]       group_bit_ff, group_bit_in;
   logic [STEP_W-1:0] time_step_ff, time_step_in;
   logic [STEP_W-1:0] force_scale_ff, force_scale_in;
   logic              sel;

   always_comb begin
      step_mode_in   = step_mode_ff;
      weighting_in   = weighting_ff;
      group_bit_in   = group_bit_ff;
      time_step_in   = time_step_ff;
      force_scale_in = force_scale_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_STEP_MODE:    step_mode_in   = csr_wdata[MODE_W-1:0];
            CSR_WEIGHTING_ON: weighting_in   = csr_wdata[0];
            CSR_GROUP_BIT:    group_bit_in   = csr_wdata;
            CSR_TIME_STEP:    time_step_in   = csr_wdata[STEP_W-1:0];
            CSR_FORCE_SCALE:  force_scale_in = csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_mode_ff   <= 2'd2;
         weighting_ff   <= 1'b0;
         group_bit_ff   <= 32'd1;
         time_step_ff   <= STEP_W'(65536);
         force_scale_ff <= STEP_W'(32768);
      end else begin
         step_mode_ff   <= step_mode_in;
         weighting_ff   <= weighting_in;
         group_bit_ff   <= group_bit_in;
         time_step_ff   <= time_step_in;
         force_scale_ff <= force_scale_in;
      end
   end

   // Classify: unselected particles carry no kick and no drift.
   assign sel = |(req_data.group_mask & group_bit_ff);

   always_comb begin
      push_data.item          = req_data;
      push_data.ctrl.sel      = sel;
      push_data.ctrl.do_kick  = sel && (step_mode_ff != MODE_DRIFT);
      push_data.ctrl.do_drift = sel && (step_mode_ff != MODE_KICK);
      push_data.ctrl.weight   = weighting_ff;
   end

   assign busy = q_full;
   assign push = start && !q_full;
   assign cfg.time_step   = time_step_ff;
   assign cfg.force_scale = force_scale_ff;

endmodule

FILE: hw/rtl/vkd_queue.sv
// Short request queue between the front end and the integration pipeline.
module vkd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  vkd_pkg::entry_type push_data,
   input  logic               pop,
   output vkd_pkg::entry_type head,
   output logic               empty,
   output logic               full
);
   import vkd_pkg::*;

   entry_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("queue popped while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count lost a push");

endmodule

FILE: hw/rtl/vkd_lane.sv
// One coordinate lane: kick product, pipelined divide, velocity clip, drift.
module vkd_lane (
   input  logic                        clock,
   input  vkd_pkg::lane_in_type        lane_in,
   input  logic [vkd_pkg::DEN_W-1:0]   den,
   input  vkd_pkg::cfg_type            cfg,
   output logic signed [31:0]          new_pos,
   output logic signed [31:0]          new_vel,
   output logic                        sel,
   output logic                        sat
);
   import vkd_pkg::*;

   // Stage 1: force magnitude times force scale.
   logic [PROD_W-1:0] prod_ff;
   lane_in_type       s1_ff;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mag32(lane_in.frc)) * PROD_W'(cfg.force_scale);
      s1_ff   <= lane_in;
   end

   // Stage 2: scale numerator, clamp check, seed the divider.
   logic [REM_W-1:0]  rem_ff  [QUO_W+1];
   logic [QUO_W-1:0]  quo_ff  [QUO_W+1];
   logic [DEN_W-1:0]  den_ff  [QUO_W+1];
   lane_side_type     side_ff [QUO_W+1];

   logic [REM_W-1:0] num;
   logic             clamp;

   always_comb begin
      num   = s1_ff.ctrl.weight ? (REM_W'(prod_ff) << FRAC_BITS) : REM_W'(prod_ff);
      clamp = num >= (REM_W'(den) << QUO_W);
   end

   always_ff @(posedge clock) begin
      rem_ff[0]          <= clamp ? '0 : num;
      quo_ff[0]          <= '0;
      den_ff[0]          <= den;
      side_ff[0].pos     <= s1_ff.pos;
      side_ff[0].vel     <= s1_ff.vel;
      side_ff[0].neg     <= s1_ff.frc[31];
      side_ff[0].kick_ok <= s1_ff.ctrl.do_kick && (den != '0);
      side_ff[0].clamp   <= clamp;
      side_ff[0].drift   <= s1_ff.ctrl.do_drift;
      side_ff[0].sel     <= s1_ff.ctrl.sel;
   end

   // Restoring divide, one quotient bit per stage, most significant first.
   for (genvar s = 0; s < QUO_W; s++) begin : g_div
      localparam int BIT = QUO_W - 1 - s;
      logic [REM_W-1:0] trial;
      logic             take;
      always_comb begin
         trial = REM_W'(den_ff[s]) << BIT;
         take  = rem_ff[s] >= trial;
      end
      always_ff @(posedge clock) begin
         rem_ff[s+1]  <= take ? rem_ff[s] - trial : rem_ff[s];
         quo_ff[s+1]  <= quo_ff[s] | (QUO_W'(take) << BIT);
         den_ff[s+1]  <= den_ff[s];
         side_ff[s+1] <= side_ff[s];
      end
   end

   // Kick stage: clamp step, apply with sign of force, clip velocity.
   lane_side_type      sk;
   logic [QUO_W-1:0]   dk;
   logic signed [SUM_W-1:0] vsum;
   clip_type           vclip;
   logic signed [31:0] v1_ff, x1_ff;
   logic               sat1_ff, drift1_ff, sel1_ff;

   always_comb begin
      sk    = side_ff[QUO_W];
      dk    = (sk.clamp || quo_ff[QUO_W] > HUGE_STEP) ? HUGE_STEP : quo_ff[QUO_W];
      vsum  = sk.neg ? SUM_W'(sk.vel) - $signed(SUM_W'(dk))
                     : SUM_W'(sk.vel) + $signed(SUM_W'(dk));
      vclip = clip_word(vsum);
   end

   always_ff @(posedge clock) begin
      v1_ff     <= sk.kick_ok ? vclip.word : sk.vel;
      sat1_ff   <= sk.kick_ok && vclip.sat;
      x1_ff     <= sk.pos;
      drift1_ff <= sk.drift;
      sel1_ff   <= sk.sel;
   end

   // Drift product: velocity magnitude times time step.
   logic [PROD_W-1:0]  dprod_ff;
   logic signed [31:0] v2_ff, x2_ff;
   logic               sat2_ff, drift2_ff, sel2_ff;

   always_ff @(posedge clock) begin
      dprod_ff  <= PROD_W'(mag32(v1_ff)) * PROD_W'(cfg.time_step);
      v2_ff     <= v1_ff;
      x2_ff     <= x1_ff;
      sat2_ff   <= sat1_ff;
      drift2_ff <= drift1_ff;
      sel2_ff   <= sel1_ff;
   end

   // Drift add and position clip.
   logic signed [SUM_W-1:0] xsum;
   logic [PROD_W-1:0]       dstep;
   clip_type                xclip;
   logic signed [31:0]      pos_ff, vel_ff;
   logic                    sat_ff, sel_ff;

   always_comb begin
      dstep = dprod_ff >> FRAC_BITS;
      xsum  = v2_ff[31] ? SUM_W'(x2_ff) - $signed(SUM_W'(dstep))
                        : SUM_W'(x2_ff) + $signed(SUM_W'(dstep));
      xclip = clip_word(xsum);
   end

   always_ff @(posedge clock) begin
      pos_ff <= drift2_ff ? xclip.word : x2_ff;
      sat_ff <= sat2_ff || (drift2_ff && xclip.sat);
      vel_ff <= v2_ff;
      sel_ff <= sel2_ff;
   end

   assign new_pos = pos_ff;
   assign new_vel = vel_ff;
   assign sel     = sel_ff;
   assign sat     = sat_ff;

endmodule

FILE: hw/rtl/vkd_back.sv
// Back end: drains the queue into three coordinate lanes and forms the response.
module vkd_back (
   input  logic               clock,
   input  logic               reset,
   input  vkd_pkg::entry_type head,
   input  logic               empty,
   output logic               pop,
   input  vkd_pkg::cfg_type   cfg,
   output logic               rsp_valid,
   output vkd_pkg::rsp_type   rsp_data
);
   import vkd_pkg::*;

   logic [DEN_W-1:0]    den_ff;
   logic [LANE_LAT-1:0] vld_ff;
   lane_in_type         lin [3];
   logic signed [31:0]  npos [3];
   logic signed [31:0]  nvel [3];
   logic [2:0]          lsel, lsat;

   // The pipeline never stalls, so take the head whenever there is one.
   assign pop = !empty;

   always_ff @(posedge clock) begin
      den_ff <= head.ctrl.weight
                ? DEN_W'(head.item.particle_mass) * DEN_W'(head.item.particle_weight)
                : DEN_W'(head.item.particle_mass);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LANE_LAT-2:0], pop};
      end
   end

   always_comb begin
      lin[0] = '{pos: head.item.pos_x, vel: head.item.vel_x, frc: head.item.force_x,
                 ctrl: head.ctrl};
      lin[1] = '{pos: head.item.pos_y, vel: head.item.vel_y, frc: head.item.force_y,
                 ctrl: head.ctrl};
      lin[2] = '{pos: head.item.pos_z, vel: head.item.vel_z, frc: head.item.force_z,
                 ctrl: head.ctrl};
   end

   for (genvar i = 0; i < 3; i++) begin : g_lane
      vkd_lane u_lane (
         .clock   (clock),
         .lane_in (lin[i]),
         .den     (den_ff),
         .cfg     (cfg),
         .new_pos (npos[i]),
         .new_vel (nvel[i]),
         .sel     (lsel[i]),
         .sat     (lsat[i])
      );
   end

   assign rsp_valid = vld_ff[LANE_LAT-1];

   always_comb begin
      rsp_data.new_pos_x    = npos[0];
      rsp_data.new_pos_y    = npos[1];
      rsp_data.new_pos_z    = npos[2];
      rsp_data.new_vel_x    = nvel[0];
      rsp_data.new_vel_y    = nvel[1];
      rsp_data.new_vel_z    = nvel[2];
      rsp_data.was_selected = lsel[0];
      rsp_data.saturated    = |lsat;
   end

   a_lanes_agree: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (lsel[0] == lsel[1]) && (lsel[1] == lsel[2]))
      else $error("lanes out of step");
   a_pass_no_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.was_selected) |-> !rsp_data.saturated)
      else $error("unselected particle flagged saturated");

endmodule

FILE: hw/rtl/verlet_kick_drift_particle.sv
// Top level of the velocity Verlet kick/drift particle integrator.
//
// One particle per request, one response per request, in order. A request is
// taken at a clock edge with start high and busy low; busy rises only if the
// four-entry request queue fills, which cannot happen in steady use because
// the integration pipeline drains one request every cycle: a new particle can
// be issued on every clock. Each response appears on rsp_data for exactly one
// cycle with rsp_valid high, after the request is drained from the queue
// (normally the cycle after it is taken). The receiver cannot stall and must
// take every response as it comes. Each response passes through the force
// product, the numerator setup, the 35-stage restoring divider inside each
// coordinate lane, the velocity clip, the drift product and the position clip.
// Configuration is written through csr_we/csr_index/csr_wdata, one register a
// cycle, and must only change while no request is in flight.
module verlet_kick_drift_particle (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  vkd_pkg::req_type              req_data,
   output logic                          rsp_valid,
   output vkd_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [vkd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_wdata
);
   import vkd_pkg::*;

   logic      push, pop, q_empty, q_full;
   entry_type push_data, head;
   cfg_type   cfg;

   // Accept, classify against the group mask, hold the live configuration.
   vkd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .push      (push),
      .push_data (push_data),
      .cfg       (cfg)
   );

   // Decouple acceptance from the integration pipeline.
   vkd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .empty     (q_empty),
      .full      (q_full)
   );

   // Kick, divide, drift and saturate per coordinate.
   vkd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .empty     (q_empty),
      .pop       (pop),
      .cfg       (cfg),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
